FILE: rtl/scalar_kalman_filter_assert.svh
// Assertion macros used by the scalar Kalman filter checker.
`ifndef SCALAR_KALMAN_FILTER_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SKF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/skf_pkg.sv
// Shared widths, register codes and types of the scalar Kalman filter.
package skf_pkg;

  localparam int VOLT_W     = 16;               // Q2.14 voltage
  localparam int VAR_W      = 32;               // Q16.16 variance
  localparam int GAIN_FRAC  = 16;               // gain fraction bits
  localparam int GAIN_W     = GAIN_FRAC + 1;    // gain reaches exactly 1.0
  localparam int SUM_W      = VAR_W + 1;        // R + P without overflow
  localparam int PROD_W     = GAIN_W + VAR_W;   // shared multiplier product
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

  localparam logic [VAR_W-1:0]  MEAS_VAR_RST = 32'h0001_0000;
  localparam logic [VOLT_W-1:0] INIT_EST_RST = '0;
  localparam logic [VAR_W-1:0]  INIT_VAR_RST = 32'h0001_0000;
  localparam logic [VOLT_W-1:0] CUR_EST_RST  = '0;
  localparam logic [VAR_W-1:0]  CUR_VAR_RST  = 32'h0001_0000;

  // Register index, taken from paddr word bits.
  typedef enum logic [1:0] {
    REG_MEAS_VAR = 2'd0,
    REG_INIT_EST = 2'd1,
    REG_INIT_VAR = 2'd2
  } cfg_reg_t;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/skf_div.sv
// Bit-serial restoring divider that forms the Q1.16 gain P*2^16 / D.
module skf_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [skf_pkg::VAR_W-1:0]        num,
  input  logic [skf_pkg::SUM_W-1:0]        den,
  output logic [skf_pkg::GAIN_W-1:0]       quot,
  output skf_pkg::div_stat_t               stat
);

  localparam int CNT_W = $clog2(skf_pkg::GAIN_W);

  logic [skf_pkg::SUM_W-1:0]  rem_r;
  logic [skf_pkg::SUM_W-1:0]  den_r;
  logic [skf_pkg::GAIN_W-1:0] nbits_r;
  logic [skf_pkg::GAIN_W-1:0] quot_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       zero_r;
  logic                       busy_r;
  logic                       done_r;

  logic [skf_pkg::SUM_W:0]    rem_sh;
  logic [skf_pkg::SUM_W:0]    rem_sub;
  logic                       ge;
  logic [skf_pkg::SUM_W-1:0]  rem_nxt;

  // One quotient bit per cycle while busy: shift in the next dividend bit, trial subtract.
  always_comb begin
    rem_sh  = {rem_r, nbits_r[skf_pkg::GAIN_W-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_sub = rem_sh - {1'b0, den_r};
    rem_nxt = ge ? rem_sub[skf_pkg::SUM_W-1:0] : rem_sh[skf_pkg::SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // Upper dividend bits P[31:1] sit below D already; seed the remainder.
        rem_r   <= skf_pkg::SUM_W'(num >> 1);
        nbits_r <= {num[0], {(skf_pkg::GAIN_W-1){1'b0}}};
        den_r   <= den;
        zero_r  <= (den == '0);
        quot_r  <= '0;
        cnt_r   <= CNT_W'(skf_pkg::GAIN_W - 1);
        busy_r  <= 1'b1;
      end else if (busy_r) begin
        rem_r   <= rem_nxt;
        nbits_r <= nbits_r << 1;
        quot_r  <= {quot_r[skf_pkg::GAIN_W-2:0], ge};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Zero denominator forces a zero gain.
  assign quot      = zero_r ? '0 : quot_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: rtl/scalar_kalman_filter.sv
// Each item: accept, start the gain divide, wait for it, step product, variance product, output hand-off.
// in_tready is low while an item is in work, so a new item waits until the last one is finished.
// A finished result waits in the output register while the next item is taken.
// Work per item is set by the bit-serial divider and the one shared 17x32 multiplier.
// Reset (synchronous, rst_n low): configuration registers to defaults, estimate 0, variance 1.0.
module scalar_kalman_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  // input item
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // [15:0] sample
  input  logic [0:0]                         in_tuser,   // [0] restart
  // result item
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [47:0]                        out_tdata,  // [15:0] estimate, [47:16] variance
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [skf_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [skf_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [skf_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,      // restart applied; start the gain divide
    ST_DIV,       // wait for the divider
    ST_MUL_STEP,  // gain * |sample - estimate|
    ST_MUL_VAR,   // apply step; (1 - gain) * variance
    ST_FIN        // hand the result to the output register
  } st_t;

  st_t                              state_r;

  // configuration registers
  logic [skf_pkg::VAR_W-1:0]        meas_var_r;
  logic [skf_pkg::VOLT_W-1:0]       init_est_r;
  logic [skf_pkg::VAR_W-1:0]        init_var_r;

  // filter state kept between items
  logic [skf_pkg::VOLT_W-1:0]       cur_est_r;
  logic [skf_pkg::VAR_W-1:0]        cur_var_r;

  // working registers of the item in flight
  logic [skf_pkg::VOLT_W-1:0]       z_r;
  logic [skf_pkg::VOLT_W-1:0]       x_r;
  logic [skf_pkg::VAR_W-1:0]        p_r;
  logic [skf_pkg::PROD_W-1:0]       prod_r;

  // output register
  logic                             out_valid_r;
  logic [skf_pkg::VOLT_W-1:0]       out_est_r;
  logic [skf_pkg::VAR_W-1:0]        out_var_r;

  logic                             in_acc;
  logic                             cfg_wr;
  skf_pkg::cfg_reg_t                cfg_idx;

  logic                             div_start;
  logic [skf_pkg::SUM_W-1:0]        div_den;
  logic [skf_pkg::GAIN_W-1:0]       gain;
  skf_pkg::div_stat_t               div_stat;

  logic                             up;
  logic [skf_pkg::VOLT_W-1:0]       abs_diff;
  logic [skf_pkg::VOLT_W-1:0]       step;
  logic [skf_pkg::VAR_W-1:0]        var_new;
  logic [skf_pkg::GAIN_W-1:0]       mul_a;
  logic [skf_pkg::VAR_W-1:0]        mul_b;
  logic [skf_pkg::PROD_W-1:0]       mul_p;
  logic                             out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_var_r, out_est_r};
  assign out_free   = !out_valid_r || out_tready;

  // ---------------------------------------------------------------------------
  // Configuration port: write on the access phase, index from the word address.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = skf_pkg::cfg_reg_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_idx)
      skf_pkg::REG_MEAS_VAR: cfg_prdata = meas_var_r;
      skf_pkg::REG_INIT_EST: cfg_prdata = skf_pkg::CFG_DATA_W'(init_est_r);
      skf_pkg::REG_INIT_VAR: cfg_prdata = init_var_r;
      default:               cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Gain divider: g = P * 2^16 / (R + P).
  // ---------------------------------------------------------------------------
  assign div_start = (state_r == ST_PREP);
  assign div_den   = {1'b0, meas_var_r} + {1'b0, p_r};

  skf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (p_r),
    .den   (div_den),
    .quot  (gain),
    .stat  (div_stat)
  );

  // ---------------------------------------------------------------------------
  // Shared multiplier: step product first, then variance product.
  // ---------------------------------------------------------------------------
  always_comb begin
    up       = (z_r >= x_r);
    abs_diff = up ? (z_r - x_r) : (x_r - z_r);
    if (state_r == ST_MUL_STEP) begin
      mul_a = gain;
      mul_b = skf_pkg::VAR_W'(abs_diff);
    end else begin
      mul_a = skf_pkg::GAIN_ONE - gain;
      mul_b = p_r;
    end
    mul_p   = skf_pkg::PROD_W'(mul_a) * skf_pkg::PROD_W'(mul_b);
    // step never exceeds |sample - estimate|, so it fits a voltage
    step    = prod_r[skf_pkg::GAIN_FRAC +: skf_pkg::VOLT_W];
    var_new = prod_r[skf_pkg::GAIN_FRAC +: skf_pkg::VAR_W];
  end

  // ---------------------------------------------------------------------------
  // Sequencer, registers and output hold.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      meas_var_r  <= skf_pkg::MEAS_VAR_RST;
      init_est_r  <= skf_pkg::INIT_EST_RST;
      init_var_r  <= skf_pkg::INIT_VAR_RST;
      cur_est_r   <= skf_pkg::CUR_EST_RST;
      cur_var_r   <= skf_pkg::CUR_VAR_RST;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          skf_pkg::REG_MEAS_VAR: meas_var_r <= cfg_pwdata;
          skf_pkg::REG_INIT_EST: init_est_r <= cfg_pwdata[skf_pkg::VOLT_W-1:0];
          skf_pkg::REG_INIT_VAR: init_var_r <= cfg_pwdata;
          default: ;  // drop writes beyond the register list
        endcase
      end

      // raise on a new result, drop once the sink takes the old one
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            // restart takes the initial estimate and variance in place of the kept state
            z_r     <= in_tdata[skf_pkg::VOLT_W-1:0];
            x_r     <= in_tuser[0] ? init_est_r : cur_est_r;
            p_r     <= in_tuser[0] ? init_var_r : cur_var_r;
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state_r <= ST_MUL_STEP;
          end
        end
        ST_MUL_STEP: begin
          prod_r  <= mul_p;
          state_r <= ST_MUL_VAR;
        end
        ST_MUL_VAR: begin
          // truncate toward zero: step moves the estimate toward the sample
          x_r     <= up ? (x_r + step) : (x_r - step);
          prod_r  <= mul_p;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_est_r   <= x_r;
            out_var_r   <= var_new;
            cur_est_r   <= x_r;
            cur_var_r   <= var_new;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/skf_checker.sv
// Port-level checker of the scalar Kalman filter, bound to the top level.
`include "scalar_kalman_filter_assert.svh"

module skf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // An accepted item keeps the block busy on the next cycle.
  `SKF_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")

  // A new result appears only as the sequencer returns to idle.
  `SKF_ASSERT_SAME(a_ready_with_result, $rose(out_tvalid), in_tready, "result while busy")

  // A stalled result holds its data.
  `SKF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed under stall")

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
